FILE: rtl/adtq_pkg.sv
// adtq_pkg: shared types, codes and constants of the deadline timer queue
// depends on nothing
package adtq_pkg;

    localparam int SLOT_COUNT_DEF       = 16;
    localparam int ENTRIES_PER_SLOT_DEF = 4;
    localparam int TAG_BITS_DEF         = 16;
    localparam int MAX_RESULTS          = 64;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_REGISTERED = 3'd0,
        KIND_FIRED      = 3'd1,
        KIND_CANCELED   = 3'd2,
        KIND_NEXT       = 3'd3,
        KIND_NONE_DUE   = 3'd4,
        KIND_FULL       = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND,
        ST_SCAN,
        ST_INSERT,
        ST_CANCEL,
        ST_TSCAN,
        ST_TCHK,
        ST_TEMIT,
        ST_TFREE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic round;
        logic scan_start;
        logic scan_step;
        logic do_insert;
        logic do_cancel;
        logic emit_step;
        logic free_slot;
        logic out_set;
        logic [2:0] out_kind;
        logic out_last;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] in_cmd;
        logic [1:0] cmd;
        logic div_done;
        logic scan_done;
        logic best_valid;
        logic best_due;
        logic emit_done;
        logic emit_live;
        logic emitted_any;
        logic out_busy;
    } stat_t;

endpackage

FILE: rtl/adtq_if.sv
// adtq_if: valid/ready channel interfaces
// depends on nothing
interface adtq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] span;
    logic [63:0] now;
    logic [15:0] handle;
    logic [63:0] cancel_time;
    logic [2:0]  cancel_id;
    modport source (output valid, command, span, now, handle, cancel_time, cancel_id,
                    input ready);
    modport sink (input valid, command, span, now, handle, cancel_time, cancel_id,
                  output ready);
endinterface

interface adtq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] deadline;
    logic [2:0]  entry_id;
    logic [15:0] fired_handle;
    logic        last;
    modport source (output valid, kind, deadline, entry_id, fired_handle, last,
                    input ready);
    modport sink (input valid, kind, deadline, entry_id, fired_handle, last,
                  output ready);
endinterface

interface adtq_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: rtl/aligned_deadline_timer_queue.sv
// aligned_deadline_timer_queue: top level of the deadline timer queue
// accept to result word: insert runs divide, round, slot scan and store in that order,
// cancel and query run a slot scan and then a decide step
// tick: slot scan, then for each due slot an emit pass over its entries and a slot free, then a closing scan
// one command at a time, next accepted on return to idle after its last word, plus output stalls
// reset clears control state, slot and live marks; depends on adtq_pkg, adtq_if, adtq_ctrl, adtq_dp
module aligned_deadline_timer_queue #(
    parameter int SLOT_COUNT       = adtq_pkg::SLOT_COUNT_DEF,
    parameter int ENTRIES_PER_SLOT = adtq_pkg::ENTRIES_PER_SLOT_DEF,
    parameter int TAG_BITS         = adtq_pkg::TAG_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    adtq_in_if.sink    in_ch,
    adtq_out_if.source out_ch,
    adtq_cfg_if.sink   cfg
);
    import adtq_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    assign cfg.ready = 1'b1;

    adtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    adtq_dp #(
        .SLOT_COUNT       (SLOT_COUNT),
        .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT),
        .TAG_BITS         (TAG_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (in_ch.command),
        .span         (in_ch.span),
        .now          (in_ch.now),
        .handle       (in_ch.handle),
        .cancel_time  (in_ch.cancel_time),
        .cancel_id    (in_ch.cancel_id),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .kind         (out_ch.kind),
        .deadline     (out_ch.deadline),
        .entry_id     (out_ch.entry_id),
        .fired_handle (out_ch.fired_handle),
        .last         (out_ch.last),
        .ctrl         (ctrl),
        .stat         (stat)
    );
endmodule

FILE: rtl/adtq_ctrl.sv
// adtq_ctrl: command sequencer of the deadline timer queue
// depends on adtq_pkg
module adtq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  adtq_pkg::stat_t stat,
    output adtq_pkg::ctrl_t ctrl
);
    import adtq_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    unique case (stat.in_cmd)
                        CMD_INSERT:
                        begin
                            ctrl.div_start = 1'b1;
                            state_next = ST_DIV;
                        end
                        CMD_CANCEL:
                        begin
                            ctrl.scan_start = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            ctrl.scan_start = 1'b1;
                            state_next = ST_TSCAN;
                        end
                    endcase
                end
            end
            ST_DIV:
                if (stat.div_done)
                    state_next = ST_ROUND;
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                ctrl.scan_start = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = (stat.cmd == CMD_INSERT) ? ST_INSERT : ST_CANCEL;
            end
            ST_INSERT:
                if (!stat.out_busy)
                begin
                    ctrl.do_insert = 1'b1;
                    ctrl.out_set = 1'b1;
                    ctrl.out_last = 1'b1;
                    ret_next = ST_IDLE;
                    state_next = ST_OUT;
                end
            ST_CANCEL:
                if (!stat.out_busy)
                begin
                    ctrl.do_cancel = 1'b1;
                    ctrl.out_set = 1'b1;
                    ctrl.out_kind = KIND_CANCELED;
                    ctrl.out_last = 1'b1;
                    ret_next = ST_IDLE;
                    state_next = ST_OUT;
                end
            ST_TSCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = ST_TCHK;
            end
            ST_TCHK:
                if (!stat.out_busy)
                begin
                    if (stat.cmd == CMD_QUERY)
                    begin
                        ctrl.out_set = 1'b1;
                        ctrl.out_kind = KIND_NEXT;
                        ctrl.out_last = 1'b1;
                        ret_next = ST_IDLE;
                        state_next = ST_OUT;
                    end
                    else if (stat.best_valid && stat.best_due)
                        state_next = ST_TEMIT;
                    else if (stat.emitted_any)
                    begin
                        ctrl.out_set = 1'b1;
                        ctrl.out_kind = KIND_FIRED;
                        ctrl.out_last = 1'b1;
                        ret_next = ST_IDLE;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ctrl.out_set = 1'b1;
                        ctrl.out_kind = KIND_NONE_DUE;
                        ctrl.out_last = 1'b1;
                        ret_next = ST_IDLE;
                        state_next = ST_OUT;
                    end
                end
            ST_TEMIT:
                if (!stat.out_busy)
                begin
                    if (stat.emit_done)
                        state_next = ST_TFREE;
                    else
                    begin
                        ctrl.emit_step = 1'b1;
                        if (stat.emit_live)
                        begin
                            ctrl.out_set = 1'b1;
                            ctrl.out_kind = KIND_FIRED;
                        end
                    end
                end
            ST_TFREE:
            begin
                ctrl.free_slot = 1'b1;
                ctrl.scan_start = 1'b1;
                state_next = ST_TSCAN;
            end
            ST_OUT:
                if (!stat.out_busy)
                    state_next = ret_reg;
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/adtq_dp.sv
// adtq_dp: slot table, divider, scanner and output register
// depends on adtq_pkg
module adtq_dp #(
    parameter int SLOT_COUNT       = adtq_pkg::SLOT_COUNT_DEF,
    parameter int ENTRIES_PER_SLOT = adtq_pkg::ENTRIES_PER_SLOT_DEF,
    parameter int TAG_BITS         = adtq_pkg::TAG_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      command,
    input  logic [63:0]     span,
    input  logic [63:0]     now,
    input  logic [15:0]     handle,
    input  logic [63:0]     cancel_time,
    input  logic [2:0]      cancel_id,
    input  logic            cfg_valid,
    input  logic [31:0]     cfg_data,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [2:0]      kind,
    output logic [63:0]     deadline,
    output logic [2:0]      entry_id,
    output logic [15:0]     fired_handle,
    output logic            last,
    input  adtq_pkg::ctrl_t ctrl,
    output adtq_pkg::stat_t stat
);
    import adtq_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EW = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1;
    localparam int FW = $clog2(ENTRIES_PER_SLOT + 1);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int NT = SLOT_COUNT * ENTRIES_PER_SLOT;
    localparam int NW = (NT > 1) ? $clog2(NT) : 1;
    localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;

    logic [31:0]   prec_reg;
    logic [1:0]    cmd_reg;
    logic [63:0]   now_reg, key_reg;
    logic [2:0]    cid_reg;
    logic [TW-1:0] hnd_reg;
    logic          noround_reg;

    logic [63:0] slot_deadline [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_used_reg;
    logic [FW-1:0] slot_fill_reg [SLOT_COUNT];
    logic [TW-1:0] entry_tag [NT];
    logic [NT-1:0] entry_live_reg;

    // restoring divider, one quotient bit a cycle
    logic [63:0] quo_reg, rem_reg;
    logic [6:0]  dcnt_reg;
    logic [32:0] rtrial;
    logic [63:0] p64;
    assign p64 = {32'd0, (prec_reg == 32'd0) ? 32'd1 : prec_reg};

    // scanner
    logic [CW-1:0] sidx_reg;
    logic          match_reg, free_reg, best_v_reg;
    logic [SW-1:0] match_s_reg, free_s_reg, best_s_reg;
    logic [63:0]   best_d_reg;
    logic [SW-1:0] si;
    assign si = sidx_reg[SW-1:0];

    logic [FW-1:0] eidx_reg;
    logic          any_reg;

    logic [64:0] sum;
    logic [63:0] dl_sat;
    assign sum    = {1'b0, span} + {1'b0, now};
    assign dl_sat = sum[64] ? ALL_ONES : sum[63:0];

    // dividend minus remainder: deadline rounded up to a multiple of precision
    logic [63:0] rounded;
    assign rounded = key_reg + (p64 - 64'd1 - rem_reg);

    logic [SW-1:0] ins_s;
    logic          ins_ok;
    logic [FW-1:0] ins_fill;
    assign ins_s    = match_reg ? match_s_reg : free_s_reg;
    assign ins_ok   = match_reg ? (slot_fill_reg[match_s_reg] < FW'(ENTRIES_PER_SLOT))
                                : free_reg;
    assign ins_fill = match_reg ? slot_fill_reg[match_s_reg] : '0;

    logic [EW-1:0] ei;
    assign ei = eidx_reg[EW-1:0];
    logic [NW-1:0] ins_addr, cnl_addr, emit_addr;
    assign ins_addr  = NW'(ins_s) * NW'(ENTRIES_PER_SLOT) + NW'(ins_fill);
    assign cnl_addr  = NW'(match_s_reg) * NW'(ENTRIES_PER_SLOT) + NW'(cid_reg - 3'd1);
    assign emit_addr = NW'(best_s_reg) * NW'(ENTRIES_PER_SLOT) + NW'(ei);

    assign stat.in_cmd      = command;
    assign stat.cmd         = cmd_reg;
    assign stat.div_done    = (dcnt_reg == 7'd0);
    assign stat.scan_done   = (sidx_reg == CW'(SLOT_COUNT - 1));
    assign stat.best_valid  = best_v_reg;
    assign stat.best_due    = (best_d_reg <= now_reg);
    assign stat.emit_done   = (eidx_reg >= slot_fill_reg[best_s_reg]);
    assign stat.emit_live   = entry_live_reg[emit_addr];
    assign stat.emitted_any = any_reg;
    assign stat.out_busy    = out_valid && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prec_reg <= 32'd1;
        else if (cfg_valid)
            prec_reg <= cfg_data;
    end

    always_comb
    begin
        rtrial = {rem_reg[31:0], quo_reg[63]} - {1'b0, p64[31:0]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            now_reg <= now;
            cid_reg <= cancel_id;
            hnd_reg <= handle[TW-1:0];
            key_reg <= (command == CMD_INSERT) ? dl_sat : cancel_time;
        end
        if (ctrl.div_start)
        begin
            quo_reg  <= dl_sat - 64'd1 + p64;
            rem_reg  <= '0;
            dcnt_reg <= 7'd64;
            noround_reg <= (ALL_ONES - dl_sat) < (p64 - 64'd1);
            // dividend is dl + p - 1, only its remainder is kept for rounding
        end
        else if (dcnt_reg != 7'd0)
        begin
            dcnt_reg <= dcnt_reg - 7'd1;
            if (!rtrial[32])
            begin
                rem_reg <= {32'd0, rtrial[31:0]};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (ctrl.round && !noround_reg)
            key_reg <= rounded;
        if (ctrl.scan_start)
        begin
            sidx_reg   <= '0;
            match_reg  <= 1'b0;
            free_reg   <= 1'b0;
            best_v_reg <= 1'b0;
            best_d_reg <= ALL_ONES;
            eidx_reg   <= '0;
        end
        else if (ctrl.scan_step)
        begin
            if (!stat.scan_done)
                sidx_reg <= sidx_reg + CW'(1);
            if (slot_used_reg[si] && slot_deadline[si] == key_reg && !match_reg)
            begin
                match_reg   <= 1'b1;
                match_s_reg <= si;
            end
            if (!slot_used_reg[si] && !free_reg)
            begin
                free_reg   <= 1'b1;
                free_s_reg <= si;
            end
            if (slot_used_reg[si] && (!best_v_reg || slot_deadline[si] < best_d_reg))
            begin
                best_v_reg <= 1'b1;
                best_s_reg <= si;
                best_d_reg <= slot_deadline[si];
            end
        end
        if (ctrl.emit_step)
            eidx_reg <= eidx_reg + FW'(1);
        if (ctrl.do_insert && ins_ok)
        begin
            slot_deadline[ins_s] <= key_reg;
            entry_tag[ins_addr] <= hnd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg  <= '0;
            entry_live_reg <= '0;
            any_reg        <= 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++)
                slot_fill_reg[s] <= '0;
        end
        else
        begin
            if (ctrl.load)
                any_reg <= 1'b0;
            if (ctrl.emit_step && stat.emit_live)
                any_reg <= 1'b1;
            if (ctrl.do_insert && ins_ok)
            begin
                slot_used_reg[ins_s] <= 1'b1;
                slot_fill_reg[ins_s] <= ins_fill + FW'(1);
                entry_live_reg[ins_addr] <= 1'b1;
            end
            if (ctrl.do_cancel && match_reg && cid_reg != 3'd0
                && 8'(cid_reg) <= 8'(slot_fill_reg[match_s_reg]))
                entry_live_reg[cnl_addr] <= 1'b0;
            if (ctrl.free_slot)
            begin
                slot_used_reg[best_s_reg] <= 1'b0;
                slot_fill_reg[best_s_reg] <= '0;
                for (int e = 0; e < ENTRIES_PER_SLOT; e++)
                    entry_live_reg[NW'(best_s_reg) * NW'(ENTRIES_PER_SLOT) + NW'(e)] <= 1'b0;
            end
        end
    end

    // output register; fired words are held back one step so last can be set
    logic       pend_reg;
    logic [63:0] pd_reg;
    logic [2:0]  pid_reg;
    logic [15:0] ph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (ctrl.out_set)
            begin
                if (ctrl.out_kind == KIND_FIRED && !ctrl.out_last)
                begin
                    pend_reg <= 1'b1;
                    if (pend_reg)
                        out_valid <= 1'b1;
                end
                else if (ctrl.out_kind == KIND_FIRED)
                begin
                    pend_reg  <= 1'b0;
                    out_valid <= 1'b1;
                end
                else
                    out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_set)
        begin
            if (ctrl.out_kind == KIND_FIRED && !ctrl.out_last)
            begin
                pd_reg  <= best_d_reg;
                pid_reg <= 3'(eidx_reg + FW'(1));
                ph_reg  <= 16'(entry_tag[emit_addr]);
                kind         <= KIND_FIRED;
                deadline     <= pd_reg;
                entry_id     <= pid_reg;
                fired_handle <= ph_reg;
                last         <= 1'b0;
            end
            else if (ctrl.out_kind == KIND_FIRED)
            begin
                kind         <= KIND_FIRED;
                deadline     <= pd_reg;
                entry_id     <= pid_reg;
                fired_handle <= ph_reg;
                last         <= 1'b1;
            end
            else
            begin
                kind         <= (cmd_reg == CMD_INSERT && !ins_ok) ? KIND_FULL
                              : ctrl.out_kind;
                deadline     <= (cmd_reg == CMD_INSERT) ? key_reg
                              : (ctrl.out_kind == KIND_NEXT) ? best_d_reg : 64'd0;
                entry_id     <= (cmd_reg == CMD_INSERT && ins_ok) ? 3'(ins_fill + FW'(1))
                              : 3'd0;
                fired_handle <= 16'd0;
                last         <= ctrl.out_last;
            end
        end
    end

    unused_rounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.round |-> (noround_reg || rounded >= key_reg))
        else $error("rounded deadline below raw deadline");
    out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(kind))
        else $error("output word changed while stalled");
    ins_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_set |-> !(out_valid && !out_ready))
        else $error("output overwritten while stalled");
    div_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.round |-> dcnt_reg == 7'd0)
        else $error("round before divide finished");
endmodule
